// ===== rtl/core/bwlp_pkg.sv =====
// Shared constants for the third-order low-pass IIR unit.
// Holds the fixed-point coefficients and the feedback loop timing constant.
// No dependencies.
package bwlp_pkg;

    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 27;
    localparam int INV_W     = 23;
    localparam int INV_FRAC  = 32;

    localparam logic signed [COEF_W-1:0] CX1 = 32'sd665185217;
    localparam logic signed [COEF_W-1:0] CX2 = 32'sd1324467012;
    localparam logic signed [COEF_W-1:0] CY2 = 32'sd73254269;
    localparam logic signed [COEF_W-1:0] CY3 = -32'sd263802424;
    localparam logic signed [COEF_W-1:0] CY4 = 32'sd321982866;

    localparam logic signed [INV_W-1:0] INV_GAIN = 23'sd2813959;

    localparam int NUM_FB_TAPS = 3;
    localparam logic signed [COEF_W-1:0] FB_COEF [NUM_FB_TAPS] = '{CY2, CY3, CY4};

    typedef logic [1:0] prod_age_t;
    localparam prod_age_t PROD_LAT = 2'd2;

endpackage

// ===== rtl/core/bwlp_ff_path.sv =====
// Feed-forward path of the low-pass IIR unit: input tap line and an elastic
// five-stage pipeline that produces the scaled input term.
// Depends on bwlp_pkg.
module bwlp_ff_path import bwlp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    output logic                                   preload_en,
    output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] preload_value,
    output logic                                   xs_valid,
    input  logic                                   xs_take,
    output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] xs
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int YW   = SAMPLE_WIDTH + FRAC_BITS;
    localparam int XW   = SW + 1 + COEF_W;
    localparam int HW   = XW - INV_FRAC;
    localparam int LW   = INV_FRAC + 1 + INV_W;
    localparam int MHW  = HW + INV_W;
    localparam int SHR  = COEF_FRAC + INV_FRAC - FRAC_BITS;
    localparam int MW   = SHR + YW;
    localparam int NTAP = 5;
    localparam int NSTG = 5;
    localparam logic signed [MW-1:0] HALF = MW'(1) << (SHR - 1);

    logic signed [SW-1:0]  tap_reg [NTAP];
    logic                  primed_reg;
    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       vld_next;
    logic [NSTG-1:0]       stg_rdy;
    logic [NSTG-1:0]       stg_in;
    logic [NSTG-1:0]       stg_load;

    logic signed [SW-1:0]  h [NTAP];
    logic signed [SW:0]    sa_next, sb_next, sc_next;
    logic signed [SW:0]    sa_reg, sb_reg, sc_reg;
    logic signed [XW-1:0]  pa_next, pb_next, pc_next;
    logic signed [XW-1:0]  pa_reg, pb_reg, pc_reg;
    logic signed [XW-1:0]  xw_reg;
    logic signed [LW-1:0]  mlo_next, mlo_reg;
    logic signed [MHW-1:0] mhi_next, mhi_reg;
    logic signed [MW-1:0]  mw;
    logic signed [YW-1:0]  xs_reg;

    always_comb
    begin
        stg_rdy[NSTG-1] = !vld_reg[NSTG-1] || xs_take;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_rdy[k] = !vld_reg[k] || stg_rdy[k+1];
        end
        stg_in[0] = in_valid;
        for (int k = 1; k < NSTG; k++)
        begin
            stg_in[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            vld_next[k] = stg_rdy[k] ? stg_in[k] : vld_reg[k];
            stg_load[k] = stg_rdy[k] && stg_in[k];
        end
    end

    assign in_ready      = stg_rdy[0];
    assign preload_en    = stg_load[0] && !primed_reg;
    assign preload_value = {sample_in, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        for (int k = 0; k < NTAP; k++)
        begin
            h[k] = primed_reg ? tap_reg[k] : sample_in;
        end
        sa_next = (SW+1)'(h[0]) + (SW+1)'(sample_in);
        sb_next = (SW+1)'(h[1]) + (SW+1)'(h[4]);
        sc_next = (SW+1)'(h[2]) + (SW+1)'(h[3]);
    end

    assign pa_next  = XW'(sa_reg) <<< COEF_FRAC;
    assign pb_next  = XW'(sb_reg) * XW'(CX1);
    assign pc_next  = XW'(sc_reg) * XW'(CX2);
    assign mlo_next = LW'($signed({1'b0, xw_reg[INV_FRAC-1:0]})) * LW'(INV_GAIN);
    assign mhi_next = MHW'($signed(xw_reg[XW-1:INV_FRAC])) * MHW'(INV_GAIN);
    assign mw       = (MW'(mhi_reg) <<< INV_FRAC) + MW'(mlo_reg) + HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (stg_load[0])
            begin
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_load[0])
        begin
            for (int k = 0; k < NTAP - 1; k++)
            begin
                tap_reg[k] <= h[k+1];
            end
            tap_reg[NTAP-1] <= sample_in;
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            sc_reg <= sc_next;
        end
        if (stg_load[1])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (stg_load[2])
        begin
            xw_reg <= pa_reg + pb_reg + pc_reg;
        end
        if (stg_load[3])
        begin
            mlo_reg <= mlo_next;
            mhi_reg <= mhi_next;
        end
        if (stg_load[4])
        begin
            xs_reg <= mw[SHR +: YW];
        end
    end

    assign xs_valid = vld_reg[NSTG-1];
    assign xs       = xs_reg;

endmodule

// ===== rtl/core/bwlp_fb_cell.sv =====
// One feedback cell of the low-pass IIR unit: holds one output tap and
// forms its product with a fixed coefficient in two registered steps.
// Depends on bwlp_pkg.
module bwlp_fb_cell import bwlp_pkg::*;
#(
    parameter int                       YW   = 40,
    parameter logic signed [COEF_W-1:0] COEF = '0
)
(
    input  logic                       clk,
    input  logic                       load_en,
    input  logic signed [YW-1:0]       load_value,
    input  logic                       shift_en,
    input  logic signed [YW-1:0]       shift_in,
    output logic signed [YW-1:0]       tap,
    output logic signed [YW+COEF_W-1:0] product
);

    localparam int YLO = YW / 2;
    localparam int YHI = YW - YLO;
    localparam int PW  = YW + COEF_W;
    localparam int LOW = YLO + 1 + COEF_W;
    localparam int HIW = YHI + COEF_W;

    logic signed [YW-1:0]  tap_reg;
    logic signed [LOW-1:0] plo_reg;
    logic signed [HIW-1:0] phi_reg;
    logic signed [PW-1:0]  prod_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            tap_reg <= load_value;
        end
        else if (shift_en)
        begin
            tap_reg <= shift_in;
        end
        plo_reg  <= LOW'($signed({1'b0, tap_reg[YLO-1:0]})) * LOW'(COEF);
        phi_reg  <= HIW'($signed(tap_reg[YW-1:YLO])) * HIW'(COEF);
        prod_reg <= (PW'(phi_reg) <<< YLO) + PW'(plo_reg);
    end

    assign tap     = tap_reg;
    assign product = prod_reg;

endmodule

// ===== rtl/core/butterworth_lowpass_iir_3rd_order_unit.sv =====
// Top level of the third-order low-pass IIR unit with notch zero.
// Depends on bwlp_pkg, bwlp_ff_path and bwlp_fb_cell.
//
// One signed sample enters per item on the input channel (in_valid, in_ready,
// sample_in) and one filtered sample leaves per item on the output channel
// (out_valid, out_ready, filtered_out), in order.
// The input term goes through a five-stage pipeline that takes a new item in
// any cycle in which it has room. The feedback part is a row of three cells,
// one per stored output, whose products settle through the registers of each
// cell after the outputs shift; the output loop takes no new item until then,
// and with the closing sum that loop sets the sustained rate.
// The first item after reset fills every input and output tap with its own
// value, so the output starts at that sample. Reset empties all pipeline
// stages and forgets that first sample.
// When the receiver stalls, the result waits in the output register, one
// more result waits in the stage before it, and the input pipeline keeps
// taking items until all five of its stages are full.
module butterworth_lowpass_iir_3rd_order_unit import bwlp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_out
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int YW = SAMPLE_WIDTH + FRAC_BITS;
    localparam int PW = YW + COEF_W;
    localparam int TW = PW + 2;
    localparam int QW = TW - COEF_FRAC;
    localparam logic [YW:0] HALF_LSB = (YW+1)'(1) << (FRAC_BITS - 1);

    logic                 preload_en;
    logic signed [YW-1:0] preload_value;
    logic                 xs_valid;
    logic signed [YW-1:0] xs;
    logic                 fire;

    logic signed [YW-1:0] fb_tap  [NUM_FB_TAPS];
    logic signed [PW-1:0] fb_prod [NUM_FB_TAPS];

    prod_age_t            age_reg;
    prod_age_t            age_next;
    logic                 y_valid_reg;
    logic                 y_valid_next;
    logic signed [YW-1:0] ynew_reg;
    logic signed [YW-1:0] ynew_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [SW-1:0] filtered_out_reg;
    logic signed [SW-1:0] filtered_out_next;

    logic                 o_ready;
    logic                 y_ready;
    logic signed [TW-1:0] total;
    logic signed [QW-1:0] q;
    logic [YW:0]          r;
    logic [SW:0]          rq;

    bwlp_ff_path #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_ff_path (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .preload_en    (preload_en),
        .preload_value (preload_value),
        .xs_valid      (xs_valid),
        .xs_take       (fire),
        .xs            (xs)
    );

    for (genvar k = 0; k < NUM_FB_TAPS; k++)
    begin : g_fb
        bwlp_fb_cell #(
            .YW   (YW),
            .COEF (FB_COEF[k])
        ) u_cell (
            .clk        (clk),
            .load_en    (preload_en),
            .load_value (preload_value),
            .shift_en   (fire),
            .shift_in   ((k == NUM_FB_TAPS - 1) ? ynew_next : fb_tap[(k + 1) % NUM_FB_TAPS]),
            .tap        (fb_tap[k]),
            .product    (fb_prod[k])
        );
    end

    assign o_ready = !out_valid_reg || out_ready;
    assign y_ready = !y_valid_reg || o_ready;
    assign fire    = xs_valid && (age_reg == PROD_LAT) && y_ready;

    always_comb
    begin
        total = TW'(fb_prod[0]) + TW'(fb_prod[1]) + TW'(fb_prod[2])
              + TW'($signed({xs, 1'b1, {(COEF_FRAC-1){1'b0}}}));
        q = total[TW-1:COEF_FRAC];
        if ((&q[QW-1:YW-1]) || !(|q[QW-1:YW-1]))
        begin
            ynew_next = q[YW-1:0];
        end
        else if (q[QW-1])
        begin
            ynew_next = {1'b1, {(YW-1){1'b0}}};
        end
        else
        begin
            ynew_next = {1'b0, {(YW-1){1'b1}}};
        end

        r  = {ynew_reg[YW-1], ynew_reg} + HALF_LSB;
        rq = r[YW:FRAC_BITS];
        if (rq[SW] != rq[SW-1])
        begin
            filtered_out_next = rq[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            filtered_out_next = rq[SW-1:0];
        end

        if (fire || preload_en)
        begin
            age_next = '0;
        end
        else if (age_reg != PROD_LAT)
        begin
            age_next = age_reg + prod_age_t'(1);
        end
        else
        begin
            age_next = age_reg;
        end

        y_valid_next   = y_ready ? fire : y_valid_reg;
        out_valid_next = o_ready ? y_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg       <= '0;
            y_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            age_reg       <= age_next;
            y_valid_reg   <= y_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ynew_reg <= ynew_next;
        end
        if (o_ready && y_valid_reg)
        begin
            filtered_out_reg <= filtered_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered_out = filtered_out_reg;

    a_loop_gap_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> !fire)
        else $error("feedback loop fired on consecutive cycles");

    a_loop_gap_two: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> ##2 !fire)
        else $error("feedback loop fired before products settled");

    a_preload_empty: assert property (@(posedge clk) disable iff (!rst_n)
        preload_en |-> (!xs_valid && !y_valid_reg && !out_valid_reg))
        else $error("tap preload while items are in flight");

    a_fire_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> y_valid_reg)
        else $error("loop result lost");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for butterworth_lowpass_iir_3rd_order_unit.
// Drives a directed table and then random segments, and checks every filtered
// sample against the row's known result or a bit-exact bwlp_pkg predictor.
module tb_top import bwlp_pkg::*;
    ;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W = 16;
    localparam int XS_SHIFT = COEF_FRAC + INV_FRAC - FRAC_W;
    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM = 1830;
    localparam int PHASE_LEN = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SAMPLE_W+FRAC_W-1:0] ystate_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        sample_t sample;
        logic known;
        sample_t result;
    } stim_row_t;

    typedef enum int {SEG_NOISE, SEG_SQUARE, SEG_HOLD, SEG_SMALL} seg_kind_t;

    localparam sample_t S_MAX = sample_t'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam sample_t S_MIN = sample_t'(-(1 <<< (SAMPLE_W - 1)));
    localparam longint Y_MAX = (64'sd1 <<< (SAMPLE_W + FRAC_W - 1)) - 1;
    localparam longint Y_MIN = -Y_MAX - 1;
    localparam longint R_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint R_MIN = -R_MAX - 1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    sample_t sample_in;
    logic out_valid;
    logic out_ready;
    sample_t filtered_out;

    logic primed;
    sample_t x_hist [5];
    ystate_t y_hist [3];

    sample_t filtered_due [$];
    sample_t due_val;
    stim_row_t directed_rows [N_DIRECTED];

    int tx_idle;
    int rx_idle;
    bit hold_req;
    int items_sent;
    int results_checked;
    int mismatches;

    butterworth_lowpass_iir_3rd_order_unit #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .FRAC_BITS(FRAC_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .filtered_out(filtered_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic sample_t next_filtered(input sample_t x);
        wide_t xw;
        wide_t xs;
        wide_t acc;
        wide_t y_new;
        wide_t rounded;
        if (!primed)
        begin
            for (int i = 0; i < 5; i++)
                x_hist[i] = x;
            for (int i = 0; i < 3; i++)
                y_hist[i] = ystate_t'(wide_t'(x) <<< FRAC_W);
            primed = 1'b1;
        end
        xw = ((wide_t'(x_hist[0]) + wide_t'(x)) <<< COEF_FRAC)
           + (wide_t'(x_hist[1]) + wide_t'(x_hist[4])) * wide_t'(CX1)
           + (wide_t'(x_hist[2]) + wide_t'(x_hist[3])) * wide_t'(CX2);
        xs = (xw * wide_t'(INV_GAIN) + (wide_t'(1) <<< (XS_SHIFT - 1))) >>> XS_SHIFT;
        acc = (xs <<< COEF_FRAC)
            + wide_t'(y_hist[0]) * wide_t'(CY2)
            + wide_t'(y_hist[1]) * wide_t'(CY3)
            + wide_t'(y_hist[2]) * wide_t'(CY4);
        y_new = (acc + (wide_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (y_new > wide_t'(Y_MAX))
            y_new = wide_t'(Y_MAX);
        else if (y_new < wide_t'(Y_MIN))
            y_new = wide_t'(Y_MIN);
        for (int i = 0; i < 4; i++)
            x_hist[i] = x_hist[i + 1];
        x_hist[4] = x;
        y_hist[0] = y_hist[1];
        y_hist[1] = y_hist[2];
        y_hist[2] = ystate_t'(y_new);
        rounded = (y_new + (wide_t'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (rounded > wide_t'(R_MAX))
            rounded = wide_t'(R_MAX);
        else if (rounded < wide_t'(R_MIN))
            rounded = wide_t'(R_MIN);
        return sample_t'(rounded);
    endfunction

    task automatic push_sample(input sample_t s, input logic known, input sample_t result);
        sample_t predicted;
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample_in = s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_filtered(s);
        filtered_due.push_back(known ? result : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_served)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            out_ready = ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (filtered_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected filtered sample %0d", filtered_out);
            end
            else
            begin
                due_val = filtered_due.pop_front();
                results_checked++;
                if (filtered_out !== due_val)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Result %0d: expected %0d, got %0d",
                                 results_checked, due_val, filtered_out);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int rand_items;
        int seg_len;
        int half;
        bit pressure_done;
        seg_kind_t kind;
        sample_t level;
        sample_t s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        hold_req = 1'b0;
        primed = 1'b0;
        for (int i = 0; i < 5; i++)
            x_hist[i] = '0;
        for (int i = 0; i < 3; i++)
            y_hist[i] = '0;
        items_sent = 0;
        results_checked = 0;
        mismatches = 0;
        rand_items = 0;
        pressure_done = 1'b0;
        tx_idle = 24;
        rx_idle = 79;
        directed_rows = '{
            '{24'sd0, 1'b1, 24'sd0}, '{24'sd0, 1'b1, 24'sd0}, '{24'sd0, 1'b1, 24'sd0},
            '{S_MAX, 1'b0, 24'sd0}, '{S_MAX, 1'b0, 24'sd0}, '{S_MAX, 1'b0, 24'sd0},
            '{S_MAX, 1'b0, 24'sd0}, '{S_MAX, 1'b0, 24'sd0}, '{S_MAX, 1'b0, 24'sd0},
            '{S_MIN, 1'b0, 24'sd0}, '{S_MIN, 1'b0, 24'sd0}, '{S_MIN, 1'b0, 24'sd0},
            '{S_MIN, 1'b0, 24'sd0}, '{S_MIN, 1'b0, 24'sd0}, '{S_MIN, 1'b0, 24'sd0},
            '{24'sd1, 1'b0, 24'sd0}, '{-24'sd1, 1'b0, 24'sd0},
            '{24'sd5592405, 1'b0, 24'sd0}, '{-24'sd5592406, 1'b0, 24'sd0},
            '{24'sd0, 1'b0, 24'sd0}, '{24'sd12345, 1'b0, 24'sd0}, '{-24'sd1, 1'b0, 24'sd0}
        };
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            push_sample(directed_rows[r].sample, directed_rows[r].known,
                        directed_rows[r].result);

        while (rand_items < N_RANDOM)
        begin
            if (rand_items >= 2 * PHASE_LEN)
            begin
                tx_idle = 0;
                rx_idle = 0;
                if (!pressure_done)
                begin
                    hold_req = 1'b1;
                    pressure_done = 1'b1;
                end
            end
            else if (rand_items >= PHASE_LEN)
            begin
                tx_idle = 79;
                rx_idle = 24;
            end
            kind = seg_kind_t'($urandom_range(3));
            seg_len = $urandom_range(40, 4);
            half = $urandom_range(24, 1);
            level = sample_t'($urandom);
            for (int k = 0; k < seg_len; k++)
            begin
                case (kind)
                    SEG_NOISE: s = sample_t'($urandom);
                    SEG_SQUARE: s = ((k / half) % 2 != 0) ? S_MIN : S_MAX;
                    SEG_HOLD: s = level;
                    default: s = sample_t'(int'($urandom_range(512)) - 256);
                endcase
                push_sample(s, 1'b0, '0);
                rand_items++;
            end
        end
        in_valid = 1'b0;

        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d from the table), checked %0d results, %0d mismatches.",
                 items_sent, N_DIRECTED, results_checked, mismatches);
        $display("Covered priming, full-scale steps and square waves, both idling mixes");
        $display("and a %0d-cycle output stall.", HOLD_CYCLES);
        if (mismatches == 0 && filtered_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
